>>> rtl/cikv_pkg.sv
// ----------------------------------------------------------------------------
// cikv_pkg
// shared types, constants and the cosine weight function for the
// immersed boundary velocity interpolator
// ----------------------------------------------------------------------------
package cikv_pkg;

   localparam int SUPPORT_WIDTH     = 4;
   localparam int WEIGHT_TABLE_BITS = 10;
   localparam int QUEUE_DEPTH       = 4;
   localparam int WEIGHT_BITS       = 17;
   localparam int WC_BITS           = 30;
   localparam int SAMPLES           = SUPPORT_WIDTH * SUPPORT_WIDTH * SUPPORT_WIDTH;
   localparam int SAMPLE_BITS       = $clog2(SAMPLES);
   localparam int AXIS_BITS         = $clog2(SUPPORT_WIDTH);
   localparam int NUM_WEIGHTS       = 3 * SUPPORT_WIDTH;
   localparam int SWEEP_BITS        = $clog2(NUM_WEIGHTS + 1);
   localparam int QCOUNT_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_BITS     = 3;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIME_STEP = 3'd0;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef struct packed {
      logic               func;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic               saturated;
   } rsp_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // queue entry: for a load the three words carry the position
   typedef struct packed {
      op_type             op;
      logic               last;
      logic signed [31:0] word_x;
      logic signed [31:0] word_y;
      logic signed [31:0] word_z;
      logic [WC_BITS-1:0] wc;
   } entry_type;

   // updated position handed back to the front end
   typedef struct packed {
      logic               valid;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } upd_type;

   typedef enum logic [1:0] {
      FRONT_SWEEP,
      FRONT_IDLE,
      FRONT_WAIT
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_RUN,
      BACK_DRAIN,
      BACK_MUL_LO,
      BACK_MUL_HI,
      BACK_SUM,
      BACK_SAT,
      BACK_OUT
   } back_state_type;

   // 1 + cos(pi*idx/2^bits) in unsigned Q2.15, evaluated at elaboration
   function automatic logic [WEIGHT_BITS-1:0] wt_rom(input logic [31:0] idx, input int bits);
      logic [63:0]        t;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        h;
      logic [63:0]        w;
      logic signed [63:0] c;
      logic               neg;
      t   = 64'(idx) << (30 - bits);
      neg = 1'b0;
      if (t > (Q30_ONE >> 1)) begin
         t   = Q30_ONE - t;
         neg = 1'b1;
      end
      x  = (t * PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      h  = Q30_ONE - x2 / 90;
      h  = Q30_ONE - ((x2 * h) >> 30) / 56;
      h  = Q30_ONE - ((x2 * h) >> 30) / 30;
      h  = Q30_ONE - ((x2 * h) >> 30) / 12;
      c  = $signed(Q30_ONE) - $signed(((x2 * h) >> 30) / 2);
      if (c < 0) begin
         c = 64'sd0;
      end
      w = neg ? Q30_ONE - 64'(c) : Q30_ONE + 64'(c);
      return WEIGHT_BITS'((w + 64'd16384) >> 15);
   endfunction

endpackage

>>> rtl/ib_cosine_kernel_velocity_interp.sv
// ----------------------------------------------------------------------------
// ib_cosine_kernel_velocity_interp
// immersed boundary velocity interpolation with the 4x4x4 cosine kernel
// ----------------------------------------------------------------------------
// A load beat (func 0) sets the node position and starts a round; then 64
// sample beats (func 1) bring the fluid velocity at the 4x4x4 grid points
// around it, x outermost and z innermost. After the 64th sample one result
// beat gives p + dt * sum(v * wx * wy * wz / 64) per axis, saturated to 32
// bits, and that position carries into the next round. Throughput: a sample
// beat is taken every cycle while the four entry queue has room; a load, and
// likewise the end of each round, first runs a weight sweep (one weight
// table read per axis offset, twelve in all) before samples are taken again.
// From the pop of the 64th sample to the result beat, the update runs the
// last add, then for each axis two 16x32 partial products, a round add and
// a saturating add in turn, and last loads the result register once the
// result channel is free. The first sweep runs right out of reset, so no
// beat is taken until it ends. The user must write time_step over the
// APB-style port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ib_cosine_kernel_velocity_interp #(
   parameter int WEIGHT_TABLE_BITS = cikv_pkg::WEIGHT_TABLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cikv_pkg::req_type                    req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cikv_pkg::rsp_type                    rsp_data,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cikv_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import cikv_pkg::*;

   logic [15:0]         time_step_ff;
   logic                csr_write;

   logic                q_push;
   logic                q_pop;
   logic                q_empty;
   logic [QCOUNT_BITS-1:0] q_count;
   entry_type           q_in;
   entry_type           q_out;
   upd_type             upd;

   // register write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
      end else if (csr_write && paddr == CSR_TIME_STEP) begin
         time_step_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      case (paddr)
         CSR_TIME_STEP: prdata = {16'b0, time_step_ff};
         default:       prdata = '0;
      endcase
   end

   // front end: position, weight sweep, kernel product
   cikv_front #(
      .WEIGHT_TABLE_BITS (WEIGHT_TABLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .upd       (upd),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   // decouples the kernel pipeline from the accumulator
   cikv_fifo #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .count     (q_count)
   );

   // back end: accumulate, update, result register
   cikv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .time_step (time_step_ff),
      .q_empty   (q_empty),
      .q_entry   (q_out),
      .q_pop     (q_pop),
      .upd       (upd),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // a result beat follows only from a finished update
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(upd.valid))
      else $error("result beat without an update");

endmodule

>>> rtl/cikv_fifo.sv
// ----------------------------------------------------------------------------
// cikv_fifo
// small register queue between the front end and the accumulator
// ----------------------------------------------------------------------------
module cikv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cikv_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   // no push into a full queue unless a pop frees a slot
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < CW'(DEPTH)))
      else $error("queue overflow");

   // no pop from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue underflow");

endmodule

>>> rtl/cikv_front.sv
// ----------------------------------------------------------------------------
// cikv_front
// takes beats, keeps the node position and the per axis weights,
// forms the kernel product of each sample and queues it
// ----------------------------------------------------------------------------
module cikv_front #(
   parameter int WEIGHT_TABLE_BITS = cikv_pkg::WEIGHT_TABLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cikv_pkg::req_type                   req_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cikv_pkg::upd_type                   upd,
   input  logic [cikv_pkg::QCOUNT_BITS-1:0]    q_count,
   output logic                                q_push,
   output cikv_pkg::entry_type                 q_entry
);
   import cikv_pkg::*;

   localparam int ROM_DEPTH = (1 << WEIGHT_TABLE_BITS) + 1;
   localparam int ROM_AW    = WEIGHT_TABLE_BITS + 1;

   front_state_type state_ff, state_in;
   logic [SWEEP_BITS-1:0]  sweep_ff, sweep_in;
   logic [SAMPLE_BITS-1:0] index_ff, index_in;
   logic signed [31:0]     pos_ff [3];

   logic [WEIGHT_BITS-1:0] rom_tbl [ROM_DEPTH];
   logic [WEIGHT_BITS-1:0] rom_q_ff;
   logic [ROM_AW-1:0]      rom_addr;

   logic [WEIGHT_BITS-1:0] wgt_x_ff [SUPPORT_WIDTH];
   logic [WEIGHT_BITS-1:0] wgt_y_ff [SUPPORT_WIDTH];
   logic [WEIGHT_BITS-1:0] wgt_z_ff [SUPPORT_WIDTH];

   logic                   accept;
   logic                   is_load;
   logic                   is_last;
   logic [AXIS_BITS-1:0]   idx_i, idx_j, idx_k;

   // sweep address generation
   logic [1:0]             swp_axis;
   logic [AXIS_BITS-1:0]   swp_k;
   logic [15:0]            swp_frac;
   logic signed [19:0]     swp_r;
   logic [19:0]            swp_u;
   logic [19:0]            swp_idx;
   logic [SWEEP_BITS-1:0]  wr_slot;
   logic [1:0]             wr_axis;
   logic [AXIS_BITS-1:0]   wr_k;

   // kernel product pipeline
   logic                       a_vld_ff;
   op_type                     a_op_ff;
   logic                       a_last_ff;
   logic signed [31:0]         a_word_ff [3];
   logic [2*WEIGHT_BITS-1:0]   a_wxy_ff;
   logic [WEIGHT_BITS-1:0]     a_wz_ff;
   logic [3*WEIGHT_BITS-1:0]   a_prod;
   logic                       b_vld_ff;
   entry_type                  b_entry_ff;
   logic [QCOUNT_BITS:0]       in_flight;

   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
      assign rom_tbl[g] = wt_rom(32'(g), WEIGHT_TABLE_BITS);
   end

   assign accept  = req_valid && req_ready;
   assign is_load = (req_data.func == OP_LOAD);
   assign is_last = (index_ff == SAMPLE_BITS'(SAMPLES - 1));
   assign idx_i   = index_ff[SAMPLE_BITS-1 -: AXIS_BITS];
   assign idx_j   = index_ff[AXIS_BITS +: AXIS_BITS];
   assign idx_k   = index_ff[AXIS_BITS-1:0];

   assign in_flight = (QCOUNT_BITS+1)'(q_count) + (QCOUNT_BITS+1)'(a_vld_ff)
                    + (QCOUNT_BITS+1)'(b_vld_ff);
   assign req_ready = (state_ff == FRONT_IDLE)
                   && (in_flight < (QCOUNT_BITS+1)'(QUEUE_DEPTH));

   // weight lookup address for slot sweep_ff
   always_comb begin
      swp_axis = 2'(sweep_ff / SUPPORT_WIDTH);
      swp_k    = AXIS_BITS'(sweep_ff % SUPPORT_WIDTH);
      case (swp_axis)
         2'd0:    swp_frac = pos_ff[0][15:0];
         2'd1:    swp_frac = pos_ff[1][15:0];
         default: swp_frac = pos_ff[2][15:0];
      endcase
      swp_r = $signed(20'(swp_k) << 16) - 20'sh10000 - $signed({4'b0, swp_frac});
      swp_u = swp_r[19] ? 20'(-swp_r) : 20'(swp_r);
      swp_idx = (swp_u + (20'd1 << (16 - WEIGHT_TABLE_BITS))) >> (17 - WEIGHT_TABLE_BITS);
      if (swp_idx > (20'd1 << WEIGHT_TABLE_BITS)) begin
         swp_idx = 20'd1 << WEIGHT_TABLE_BITS;
      end
      rom_addr = swp_idx[ROM_AW-1:0];
      wr_slot  = sweep_ff - 1'b1;
      wr_axis  = 2'(wr_slot / SUPPORT_WIDTH);
      wr_k     = AXIS_BITS'(wr_slot % SUPPORT_WIDTH);
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= rom_tbl[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == FRONT_SWEEP && sweep_ff != '0) begin
         case (wr_axis)
            2'd0:    wgt_x_ff[wr_k] <= rom_q_ff;
            2'd1:    wgt_y_ff[wr_k] <= rom_q_ff;
            default: wgt_z_ff[wr_k] <= rom_q_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      index_in = index_ff;
      case (state_ff)
         FRONT_SWEEP: begin
            if (sweep_ff == SWEEP_BITS'(NUM_WEIGHTS)) begin
               sweep_in = '0;
               state_in = FRONT_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         FRONT_IDLE: begin
            if (accept) begin
               if (is_load) begin
                  index_in = '0;
                  state_in = FRONT_SWEEP;
               end else begin
                  index_in = index_ff + 1'b1;
                  if (is_last) begin
                     state_in = FRONT_WAIT;
                  end
               end
            end
         end
         FRONT_WAIT: begin
            if (upd.valid) begin
               state_in = FRONT_SWEEP;
            end
         end
         default: begin
            state_in = FRONT_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_SWEEP;
         sweep_ff <= '0;
         index_ff <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         index_ff <= index_in;
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
         if (accept && is_load) begin
            pos_ff[0] <= req_data.pos_x;
            pos_ff[1] <= req_data.pos_y;
            pos_ff[2] <= req_data.pos_z;
         end else if (state_ff == FRONT_WAIT && upd.valid) begin
            pos_ff[0] <= upd.pos_x;
            pos_ff[1] <= upd.pos_y;
            pos_ff[2] <= upd.pos_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff   <= is_load ? OP_LOAD : OP_SAMPLE;
      a_last_ff <= !is_load && is_last;
      a_word_ff[0] <= is_load ? req_data.pos_x : req_data.vel_x;
      a_word_ff[1] <= is_load ? req_data.pos_y : req_data.vel_y;
      a_word_ff[2] <= is_load ? req_data.pos_z : req_data.vel_z;
      a_wxy_ff  <= wgt_x_ff[idx_i] * wgt_y_ff[idx_j];
      a_wz_ff   <= wgt_z_ff[idx_k];
   end

   assign a_prod = a_wxy_ff * a_wz_ff;

   always_ff @(posedge clock) begin
      b_entry_ff.op     <= a_op_ff;
      b_entry_ff.last   <= a_last_ff;
      b_entry_ff.word_x <= a_word_ff[0];
      b_entry_ff.word_y <= a_word_ff[1];
      b_entry_ff.word_z <= a_word_ff[2];
      b_entry_ff.wc     <= a_prod[21 +: WC_BITS];
   end

   assign q_push  = b_vld_ff;
   assign q_entry = b_entry_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == FRONT_IDLE && sweep_ff == '0))
      else $error("beat taken while weights not settled");

   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_load && is_last) |=> (state_ff == FRONT_WAIT && index_ff == '0))
      else $error("last sample did not close the round");

endmodule

>>> rtl/cikv_back.sv
// ----------------------------------------------------------------------------
// cikv_back
// accumulates the weighted velocities and applies the position update
// ----------------------------------------------------------------------------
module cikv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         time_step,
   input  logic                q_empty,
   input  cikv_pkg::entry_type q_entry,
   output logic                q_pop,
   output cikv_pkg::upd_type   upd,
   output cikv_pkg::rsp_type   rsp_data,
   output logic                rsp_valid,
   input  logic                rsp_ready
);
   import cikv_pkg::*;

   back_state_type state_ff, state_in;
   logic [1:0]         coord_ff, coord_in;

   logic signed [63:0] acc_ff [3];
   logic signed [31:0] pos_ff [3];
   logic               prod_vld_ff;
   logic signed [62:0] prod_ff [3];

   logic [47:0]        plo_ff;
   logic signed [48:0] phi_ff;
   logic signed [81:0] sum_ff;
   logic signed [52:0] next_pos;
   logic signed [31:0] sat_pos;
   logic               sat_hit;
   logic               sat_ff;
   logic signed [63:0] acc_sel;

   logic               out_free;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               pop_load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == BACK_RUN) && !q_empty;
   assign pop_load = q_pop && (q_entry.op == OP_LOAD);
   assign acc_sel  = acc_ff[coord_ff];

   always_comb begin
      next_pos = $signed({{21{pos_ff[coord_ff][31]}}, pos_ff[coord_ff]})
               + $signed({sum_ff[81], sum_ff[81:30]});
      sat_hit  = (next_pos[52:31] != {22{next_pos[52]}});
      if (sat_hit) begin
         sat_pos = next_pos[52] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         sat_pos = next_pos[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      coord_in = coord_ff;
      case (state_ff)
         BACK_RUN: begin
            if (q_pop && q_entry.op == OP_SAMPLE && q_entry.last) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            coord_in = '0;
            state_in = BACK_MUL_LO;
         end
         BACK_MUL_LO: state_in = BACK_MUL_HI;
         BACK_MUL_HI: state_in = BACK_SUM;
         BACK_SUM:    state_in = BACK_SAT;
         BACK_SAT: begin
            if (coord_ff == 2'd2) begin
               state_in = BACK_OUT;
            end else begin
               coord_in = coord_ff + 1'b1;
               state_in = BACK_MUL_LO;
            end
         end
         BACK_OUT: begin
            if (out_free) begin
               state_in = BACK_RUN;
            end
         end
         default: state_in = BACK_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_RUN;
         coord_ff     <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            acc_ff[a] <= '0;
            pos_ff[a] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         coord_ff    <= coord_in;
         prod_vld_ff <= q_pop && (q_entry.op == OP_SAMPLE);
         if (state_ff == BACK_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // a load that follows a sample wins over its pending add
         if (pop_load || (state_ff == BACK_OUT && out_free)) begin
            for (int a = 0; a < 3; a++) begin
               acc_ff[a] <= '0;
            end
         end else if (prod_vld_ff) begin
            for (int a = 0; a < 3; a++) begin
               acc_ff[a] <= acc_ff[a] + {{25{prod_ff[a][62]}}, prod_ff[a][62:24]};
            end
         end
         if (pop_load) begin
            pos_ff[0] <= q_entry.word_x;
            pos_ff[1] <= q_entry.word_y;
            pos_ff[2] <= q_entry.word_z;
         end
         if (state_ff == BACK_DRAIN) begin
            sat_ff <= 1'b0;
         end
         if (state_ff == BACK_SAT) begin
            pos_ff[coord_ff] <= sat_pos;
            sat_ff <= sat_ff || sat_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff[0] <= q_entry.word_x * $signed({1'b0, q_entry.wc});
      prod_ff[1] <= q_entry.word_y * $signed({1'b0, q_entry.wc});
      prod_ff[2] <= q_entry.word_z * $signed({1'b0, q_entry.wc});
      plo_ff <= time_step * acc_sel[31:0];
      phi_ff <= $signed({1'b0, time_step}) * $signed(acc_sel[63:32]);
      sum_ff <= $signed({phi_ff[48], phi_ff, 32'b0}) + $signed({34'b0, plo_ff})
              + 82'sd536870912;
      if (state_ff == BACK_OUT && out_free) begin
         rsp_data_ff.new_x     <= pos_ff[0];
         rsp_data_ff.new_y     <= pos_ff[1];
         rsp_data_ff.new_z     <= pos_ff[2];
         rsp_data_ff.saturated <= sat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign upd.valid = (state_ff == BACK_OUT) && out_free;
   assign upd.pos_x = pos_ff[0];
   assign upd.pos_y = pos_ff[1];
   assign upd.pos_z = pos_ff[2];

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_OUT && out_free) |=> rsp_valid_ff)
      else $error("finished update not presented");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != BACK_RUN) |-> !prod_vld_ff || state_ff == BACK_DRAIN)
      else $error("sample add outside the accumulate phase");

endmodule
